/* rtl/owbm_pkg.sv */
// Shared types and constants for the one-wire bus master.
// Used by owbm_front, owbm_engine and one_wire_bus_master_unit; depends on nothing.
package owbm_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitIdxW = $clog2(BitsPerByte);
  localparam int unsigned TimerW = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic [TimerW-1:0] WriteRecoverUs = 12'd4;
  localparam logic [TimerW-1:0] ReadGapUs = 12'd5;

  // command request field of an input beat
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_WRITE_START   = 3'd3,
    REG_WRITE_HOLD    = 3'd4,
    REG_READ_START    = 3'd5,
    REG_READ_WAIT     = 3'd6,
    REG_READ_TAIL     = 3'd7
  } reg_idx_e;

  typedef enum logic [12:0] {
    PH_IDLE     = 13'b0000000000001,
    PH_RST_LOW  = 13'b0000000000010,
    PH_RST_WAIT = 13'b0000000000100,
    PH_RST_SMP  = 13'b0000000001000,
    PH_RST_TAIL = 13'b0000000010000,
    PH_WR_START = 13'b0000000100000,
    PH_WR_HOLD  = 13'b0000001000000,
    PH_WR_REC   = 13'b0000010000000,
    PH_RD_START = 13'b0000100000000,
    PH_RD_WAIT  = 13'b0001000000000,
    PH_RD_SMP   = 13'b0010000000000,
    PH_RD_TAIL  = 13'b0100000000000,
    PH_RD_GAP   = 13'b1000000000000
  } phase_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] tx_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_level;
    logic [7:0] rx_byte;
  } out_item_t;

  // classified beat as held in the queue between front and engine
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       line_level;
  } tick_t;

  typedef struct packed {
    logic [11:0] reset_low_us;
    logic [11:0] presence_wait_us;
    logic [11:0] reset_tail_us;
    logic [7:0]  write_start_us;
    logic [7:0]  write_hold_us;
    logic [7:0]  read_start_us;
    logic [7:0]  read_wait_us;
    logic [7:0]  read_tail_us;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    reset_low_us:     12'd500,
    presence_wait_us: 12'd50,
    reset_tail_us:    12'd200,
    write_start_us:   8'd4,
    write_hold_us:    8'd50,
    read_start_us:    8'd8,
    read_wait_us:     8'd14,
    read_tail_us:     8'd40
  };

  // a zero duration counts as one tick
  function automatic logic [TimerW-1:0] dur12(input logic [11:0] v);
    return (v == 12'd0) ? 12'd1 : v;
  endfunction

  function automatic logic [TimerW-1:0] dur8(input logic [7:0] v);
    return (v == 8'd0) ? 12'd1 : {4'd0, v};
  endfunction

endpackage

/* rtl/owbm_front.sv */
// Front end of the one-wire bus master: takes input beats, decodes the command
// and holds them in a two-entry queue for the engine. Depends on owbm_pkg.
module owbm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  owbm_pkg::in_item_t  in_item_i,
  output logic                q_valid_o,
  output owbm_pkg::tick_t     q_tick_o,
  input  logic                q_pop_i
);

  owbm_pkg::tick_t entry_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push;
  owbm_pkg::tick_t tick;

  always_comb begin
    tick.cmd        = owbm_pkg::cmd_e'(in_item_i.func);
    tick.tx_byte    = in_item_i.tx_byte;
    tick.line_level = in_item_i.line_level;
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_tick_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= tick;
    end
  end

endmodule

/* rtl/owbm_engine.sv */
// Back end of the one-wire bus master: runs the slot sequencer one tick per
// queued beat and holds the result beat in an output register. Depends on owbm_pkg.
module owbm_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  owbm_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  owbm_pkg::tick_t     q_tick_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output owbm_pkg::out_item_t out_item_o
);

  localparam logic [owbm_pkg::BitIdxW-1:0] LastBit =
    owbm_pkg::BitIdxW'(owbm_pkg::BitsPerByte - 1);

  owbm_pkg::phase_e                 phase_q, phase_d;
  logic [owbm_pkg::TimerW-1:0]      timer_q, timer_d;
  logic [owbm_pkg::BitIdxW-1:0]     bit_q, bit_d;
  logic [7:0]                       shift_out_q, shift_out_d;
  logic [7:0]                       shift_in_q, shift_in_d;
  logic                             presence_q, presence_d;
  logic                             out_valid_q, out_valid_d;
  owbm_pkg::out_item_t              out_item_q, out_item_d;

  assign q_pop_o     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    owbm_pkg::phase_e             ph;
    logic [owbm_pkg::TimerW-1:0]  tmr;
    logic [owbm_pkg::TimerW-1:0]  tail_r;
    logic [owbm_pkg::TimerW-1:0]  tail_p;
    logic                         drive;
    logic                         busy;
    logic                         done;

    ph          = phase_q;
    tmr         = timer_q;
    bit_d       = bit_q;
    shift_out_d = shift_out_q;
    shift_in_d  = shift_in_q;
    presence_d  = presence_q;
    drive       = 1'b0;
    done        = 1'b0;
    tail_r      = owbm_pkg::dur12(cfg_i.reset_tail_us);
    tail_p      = owbm_pkg::dur8(cfg_i.read_tail_us);

    // start a command only from idle
    if (phase_q == owbm_pkg::PH_IDLE) begin
      bit_d = '0;
      case (q_tick_i.cmd)
        owbm_pkg::CMD_RESET: begin
          ph  = owbm_pkg::PH_RST_LOW;
          tmr = owbm_pkg::dur12(cfg_i.reset_low_us);
        end
        owbm_pkg::CMD_WRITE: begin
          ph          = owbm_pkg::PH_WR_START;
          tmr         = owbm_pkg::dur8(cfg_i.write_start_us);
          shift_out_d = q_tick_i.tx_byte;
        end
        owbm_pkg::CMD_READ: begin
          ph         = owbm_pkg::PH_RD_START;
          tmr        = owbm_pkg::dur8(cfg_i.read_start_us);
          shift_in_d = 8'd0;
        end
        default: begin
          bit_d = bit_q;
        end
      endcase
    end

    busy    = (ph != owbm_pkg::PH_IDLE);
    phase_d = ph;
    timer_d = tmr;

    unique case (ph)
      owbm_pkg::PH_RST_LOW, owbm_pkg::PH_WR_START, owbm_pkg::PH_RD_START: drive = 1'b1;
      owbm_pkg::PH_WR_HOLD: drive = !shift_out_d[0];
      owbm_pkg::PH_RST_SMP: presence_d = q_tick_i.line_level;
      owbm_pkg::PH_RD_SMP: shift_in_d = shift_in_d | (8'(q_tick_i.line_level) << bit_d);
      default: ;
    endcase

    if (busy && tmr > 12'd1) begin
      timer_d = tmr - 12'd1;
    end else if (busy) begin
      // phase has used its last tick: advance
      unique case (ph)
        owbm_pkg::PH_RST_LOW: begin
          phase_d = owbm_pkg::PH_RST_WAIT;
          timer_d = owbm_pkg::dur12(cfg_i.presence_wait_us);
        end
        owbm_pkg::PH_RST_WAIT: begin
          phase_d = owbm_pkg::PH_RST_SMP;
          timer_d = 12'd1;
        end
        owbm_pkg::PH_RST_SMP: begin
          if (tail_r > 12'd1) begin
            phase_d = owbm_pkg::PH_RST_TAIL;
            timer_d = tail_r - 12'd1;
          end else begin
            done = 1'b1;
          end
        end
        owbm_pkg::PH_WR_START: begin
          phase_d = owbm_pkg::PH_WR_HOLD;
          timer_d = owbm_pkg::dur8(cfg_i.write_hold_us);
        end
        owbm_pkg::PH_WR_HOLD: begin
          phase_d = owbm_pkg::PH_WR_REC;
          timer_d = owbm_pkg::WriteRecoverUs;
        end
        owbm_pkg::PH_WR_REC: begin
          if (bit_d == LastBit) begin
            done = 1'b1;
          end else begin
            bit_d       = bit_d + owbm_pkg::BitIdxW'(1);
            shift_out_d = shift_out_d >> 1;
            phase_d     = owbm_pkg::PH_WR_START;
            timer_d     = owbm_pkg::dur8(cfg_i.write_start_us);
          end
        end
        owbm_pkg::PH_RD_START: begin
          phase_d = owbm_pkg::PH_RD_WAIT;
          timer_d = owbm_pkg::dur8(cfg_i.read_wait_us);
        end
        owbm_pkg::PH_RD_WAIT: begin
          phase_d = owbm_pkg::PH_RD_SMP;
          timer_d = 12'd1;
        end
        owbm_pkg::PH_RD_SMP, owbm_pkg::PH_RD_TAIL: begin
          if (ph == owbm_pkg::PH_RD_SMP && tail_p > 12'd1) begin
            phase_d = owbm_pkg::PH_RD_TAIL;
            timer_d = tail_p - 12'd1;
          end else if (bit_d == LastBit) begin
            phase_d = owbm_pkg::PH_RD_GAP;
            timer_d = owbm_pkg::ReadGapUs;
          end else begin
            bit_d   = bit_d + owbm_pkg::BitIdxW'(1);
            phase_d = owbm_pkg::PH_RD_START;
            timer_d = owbm_pkg::dur8(cfg_i.read_start_us);
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end

    if (done) begin
      phase_d = owbm_pkg::PH_IDLE;
      timer_d = '0;
    end

    out_item_d.drive_low      = drive;
    out_item_d.busy_res       = busy;
    out_item_d.done_res       = done;
    out_item_d.presence_level = presence_d;
    out_item_d.rx_byte        = shift_in_d;

    out_valid_d = q_pop_o ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= owbm_pkg::PH_IDLE;
      timer_q     <= '0;
      bit_q       <= '0;
      shift_out_q <= '0;
      shift_in_q  <= '0;
      presence_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        phase_q     <= phase_d;
        timer_q     <= timer_d;
        bit_q       <= bit_d;
        shift_out_q <= shift_out_d;
        shift_in_q  <= shift_in_d;
        presence_q  <= presence_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

/* rtl/one_wire_bus_master_unit.sv */
// Top level of the one-wire bus master: configuration registers, front queue
// and slot engine. Depends on owbm_pkg, owbm_front and owbm_engine.
//
// Usage: each input beat is one microsecond tick. It carries a command request
// (func: tick only, reset, write byte, read byte), the byte to send and the
// sampled bus level. A command is taken only while no command is running;
// otherwise it is ignored. Every input beat yields exactly one result beat with
// the open-drain drive for that tick, busy, done, the last presence level and
// the receive byte.
// A result beat passes through a queue entry and then the output register,
// where a receiver stall can hold it. Throughput: one beat per cycle while the
// receiver does not stall; the slot engine updates its state once per tick,
// so the state loop sets the rate. A two-entry queue sits between the input
// side and the engine; when the receiver stalls, the result holds, the queue
// fills and in_stall_o rises once the queue holds two beats.
// Reset clears the queue and the sequencer (bus released, presence level high)
// and loads the default slot timings. Write configuration only while idle.
module one_wire_bus_master_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  owbm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output owbm_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [11:0]         cfg_data_i
);

  owbm_pkg::cfg_t  cfg_q, cfg_d;
  logic            q_valid;
  owbm_pkg::tick_t q_tick;
  logic            q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (owbm_pkg::reg_idx_e'(cfg_idx_i))
        owbm_pkg::REG_RESET_LOW:     cfg_d.reset_low_us     = cfg_data_i;
        owbm_pkg::REG_PRESENCE_WAIT: cfg_d.presence_wait_us = cfg_data_i;
        owbm_pkg::REG_RESET_TAIL:    cfg_d.reset_tail_us    = cfg_data_i;
        owbm_pkg::REG_WRITE_START:   cfg_d.write_start_us   = cfg_data_i[7:0];
        owbm_pkg::REG_WRITE_HOLD:    cfg_d.write_hold_us    = cfg_data_i[7:0];
        owbm_pkg::REG_READ_START:    cfg_d.read_start_us    = cfg_data_i[7:0];
        owbm_pkg::REG_READ_WAIT:     cfg_d.read_wait_us     = cfg_data_i[7:0];
        owbm_pkg::REG_READ_TAIL:     cfg_d.read_tail_us     = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= owbm_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  owbm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_tick_o   (q_tick),
    .q_pop_i    (q_pop)
  );

  owbm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_tick_i    (q_tick),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* test/one_wire_bus_master_unit_test.sv */
// Self-checking bench for one_wire_bus_master_unit: a directed table, then random
// microsecond ticks across several slot timings, checked beat by beat against a
// local slot sequencer model. Depends on owbm_pkg and the RTL under rtl/.
module one_wire_bus_master_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import owbm_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles = 60;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [11:0] cfg_data_i = '0;

  one_wire_bus_master_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- sequencer model
  phase_e      bus_phase;
  logic [11:0] slot_timer;
  logic [2:0]  bit_idx;
  logic [7:0]  tx_shift;
  logic [7:0]  rx_shift;
  logic        presence_q;
  logic [11:0] timing [8];

  function automatic logic [11:0] span(input reg_idx_e r);
    return (timing[r] == 12'd0) ? 12'd1 : timing[r];
  endfunction

  // move to the next phase once the current one has used its last tick
  function automatic logic slot_advance();
    logic fin;
    fin = 1'b0;
    case (bus_phase)
      PH_RST_LOW: begin
        bus_phase = PH_RST_WAIT;
        slot_timer = span(REG_PRESENCE_WAIT);
      end
      PH_RST_WAIT: begin
        bus_phase = PH_RST_SMP;
        slot_timer = 12'd1;
      end
      PH_RST_SMP: begin
        if (span(REG_RESET_TAIL) > 12'd1) begin
          bus_phase = PH_RST_TAIL;
          slot_timer = span(REG_RESET_TAIL) - 12'd1;
        end else begin
          fin = 1'b1;
        end
      end
      PH_WR_START: begin
        bus_phase = PH_WR_HOLD;
        slot_timer = span(REG_WRITE_HOLD);
      end
      PH_WR_HOLD: begin
        bus_phase = PH_WR_REC;
        slot_timer = WriteRecoverUs;
      end
      PH_WR_REC: begin
        if (bit_idx == 3'(BitsPerByte - 1)) begin
          fin = 1'b1;
        end else begin
          bit_idx = bit_idx + 3'd1;
          tx_shift = tx_shift >> 1;
          bus_phase = PH_WR_START;
          slot_timer = span(REG_WRITE_START);
        end
      end
      PH_RD_START: begin
        bus_phase = PH_RD_WAIT;
        slot_timer = span(REG_READ_WAIT);
      end
      PH_RD_WAIT: begin
        bus_phase = PH_RD_SMP;
        slot_timer = 12'd1;
      end
      PH_RD_SMP, PH_RD_TAIL: begin
        // a one-tick tail ends the slot on the sample tick itself
        if (bus_phase == PH_RD_SMP && span(REG_READ_TAIL) > 12'd1) begin
          bus_phase = PH_RD_TAIL;
          slot_timer = span(REG_READ_TAIL) - 12'd1;
        end else if (bit_idx == 3'(BitsPerByte - 1)) begin
          bus_phase = PH_RD_GAP;
          slot_timer = ReadGapUs;
        end else begin
          bit_idx = bit_idx + 3'd1;
          bus_phase = PH_RD_START;
          slot_timer = span(REG_READ_START);
        end
      end
      default: fin = 1'b1;
    endcase
    if (fin) begin
      bus_phase = PH_IDLE;
      slot_timer = '0;
    end
    return fin;
  endfunction

  function automatic out_item_t owire_tick(input in_item_t it);
    out_item_t r;
    r = '0;
    if (bus_phase == PH_IDLE && it.func != CMD_TICK) begin
      bit_idx = '0;
      case (it.func)
        CMD_RESET: begin
          bus_phase = PH_RST_LOW;
          slot_timer = span(REG_RESET_LOW);
        end
        CMD_WRITE: begin
          tx_shift = it.tx_byte;
          bus_phase = PH_WR_START;
          slot_timer = span(REG_WRITE_START);
        end
        default: begin
          rx_shift = '0;
          bus_phase = PH_RD_START;
          slot_timer = span(REG_READ_START);
        end
      endcase
    end
    if (bus_phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      case (bus_phase)
        PH_RST_LOW, PH_WR_START, PH_RD_START: r.drive_low = 1'b1;
        PH_WR_HOLD: r.drive_low = ~tx_shift[0];
        PH_RST_SMP: presence_q = it.line_level;
        PH_RD_SMP: rx_shift = rx_shift | (8'(it.line_level) << bit_idx);
        default: ;
      endcase
      if (slot_timer <= 12'd1) begin
        r.done_res = slot_advance();
      end else begin
        slot_timer = slot_timer - 12'd1;
      end
    end
    r.presence_level = presence_q;
    r.rx_byte = rx_shift;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  out_item_t tick_res_q [$];
  int unsigned fail_count = 0;
  int unsigned res_count = 0;
  int unsigned cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_reqs = 0;
  int hold_served = 0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch beat %0d: %s got %h want %h", res_count, what, got, want);
    fail_count++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (tick_res_q.size() == 0) begin
      report_mismatch("unexpected beat", got.rx_byte, 8'h00);
    end else begin
      want = tick_res_q.pop_front();
      if (got.drive_low !== want.drive_low)
        report_mismatch("drive_low", 8'(got.drive_low), 8'(want.drive_low));
      if (got.busy_res !== want.busy_res)
        report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
      if (got.done_res !== want.done_res)
        report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
      if (got.presence_level !== want.presence_level)
        report_mismatch("presence_level", 8'(got.presence_level),
                        8'(want.presence_level));
      if (got.rx_byte !== want.rx_byte)
        report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
    end
    res_count++;
  endtask

  initial begin : result_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) check_result(out_item_o);
      if (hold_served < hold_reqs) begin
        hold_left = HoldCycles;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus
  task automatic set_mode(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // offer one beat; step the model on acceptance and queue its result, or the given result if typed
  task automatic send_beat(input in_item_t it, input logic typed = 1'b0,
                           input out_item_t typed_res = '0);
    out_item_t pred;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    pred = owire_tick(it);
    tick_res_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic tick_until_idle(input logic rand_line, input logic line);
    in_item_t it;
    while (bus_phase != PH_IDLE) begin
      it.func = CMD_TICK;
      it.tx_byte = 8'($urandom_range(255));
      it.line_level = rand_line ? 1'($urandom_range(1)) : line;
      send_beat(it);
    end
  endtask

  // finish any command, drain every result, then let the pipeline empty
  task automatic quiesce();
    tick_until_idle(1'b1, 1'b0);
    in_valid_i <= 1'b0;
    while (tick_res_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_timings(input int lo, input int hi);
    logic [11:0] v;
    reg_idx_e    ri;
    for (int i = 0; i < 8; i++) begin
      ri = reg_idx_e'(i);
      v = 12'($urandom_range(hi, lo));
      cfg_we_i <= 1'b1;
      cfg_idx_i <= ri;
      cfg_data_i <= v;
      timing[ri] = (ri < REG_WRITE_START) ? v : {4'd0, v[7:0]};
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int n_beats);
    in_item_t it;
    for (int k = 0; k < n_beats; k++) begin
      if (k == n_beats / 4) begin
        // hold the input side until the block has answered everything
        in_valid_i <= 1'b0;
        while (tick_res_q.size() != 0) @(posedge clk_i);
      end
      if (k == n_beats / 2) hold_reqs++;
      it.tx_byte = 8'($urandom_range(255));
      it.line_level = 1'($urandom_range(1));
      if (bus_phase == PH_IDLE) begin
        it.func = ($urandom_range(9) < 7) ? 2'($urandom_range(CMD_READ, CMD_RESET))
                                          : CMD_TICK;
      end else begin
        // an occasional command while busy, which must be dropped
        it.func = ($urandom_range(19) == 0) ? 2'($urandom_range(CMD_READ, CMD_RESET))
                                            : CMD_TICK;
      end
      send_beat(it);
    end
  endtask

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx;
    logic       line;
    logic       settle;
    logic       typed;
    out_item_t  res;
  } dir_row_t;

  localparam out_item_t ResIdleNoDev = '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00};
  localparam out_item_t ResIdleDev   = '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00};

  dir_row_t dir_rows [17];

  initial begin : stimulus
    in_item_t it;
    dir_rows = '{
      '{CMD_TICK,  8'h00, 1'b0, 1'b0, 1'b1, ResIdleNoDev},
      '{CMD_TICK,  8'hFF, 1'b1, 1'b0, 1'b1, ResIdleNoDev},
      // first tick of a reset pulls low
      '{CMD_RESET, 8'h00, 1'b0, 1'b0, 1'b1, out_item_t'{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
      // reset while busy is dropped; bus held low answers presence
      '{CMD_RESET, 8'hFF, 1'b0, 1'b1, 1'b0, ResIdleNoDev},
      '{CMD_TICK,  8'h00, 1'b1, 1'b0, 1'b1, ResIdleDev},
      '{CMD_WRITE, 8'h00, 1'b1, 1'b1, 1'b0, ResIdleDev},
      '{CMD_WRITE, 8'hFF, 1'b0, 1'b1, 1'b0, ResIdleDev},
      '{CMD_READ,  8'h55, 1'b1, 1'b1, 1'b0, ResIdleDev},
      '{CMD_TICK,  8'h00, 1'b0, 1'b0, 1'b1, out_item_t'{1'b0, 1'b0, 1'b0, 1'b0, 8'hFF}},
      // a read clears the receive byte on its first tick
      '{CMD_READ,  8'h00, 1'b0, 1'b0, 1'b1, out_item_t'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
      '{CMD_TICK,  8'h00, 1'b0, 1'b1, 1'b0, ResIdleDev},
      '{CMD_WRITE, 8'hA5, 1'b1, 1'b0, 1'b1, out_item_t'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
      '{CMD_READ,  8'h00, 1'b1, 1'b0, 1'b0, ResIdleDev},
      '{CMD_RESET, 8'h00, 1'b0, 1'b0, 1'b0, ResIdleDev},
      // tx byte of a dropped write is not taken
      '{CMD_WRITE, 8'h3C, 1'b1, 1'b1, 1'b0, ResIdleDev},
      '{CMD_RESET, 8'h00, 1'b1, 1'b1, 1'b0, ResIdleDev},
      '{CMD_TICK,  8'h00, 1'b0, 1'b0, 1'b1, ResIdleNoDev}
    };

    bus_phase = PH_IDLE;
    slot_timer = '0;
    bit_idx = '0;
    tx_shift = '0;
    rx_shift = '0;
    presence_q = 1'b1;
    timing[REG_RESET_LOW]     = CfgReset.reset_low_us;
    timing[REG_PRESENCE_WAIT] = CfgReset.presence_wait_us;
    timing[REG_RESET_TAIL]    = CfgReset.reset_tail_us;
    timing[REG_WRITE_START]   = {4'd0, CfgReset.write_start_us};
    timing[REG_WRITE_HOLD]    = {4'd0, CfgReset.write_hold_us};
    timing[REG_READ_START]    = {4'd0, CfgReset.read_start_us};
    timing[REG_READ_WAIT]     = {4'd0, CfgReset.read_wait_us};
    timing[REG_READ_TAIL]     = {4'd0, CfgReset.read_tail_us};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short slots keep the directed commands brief
    set_timings(1, 3);

    set_mode(24, 65);
    foreach (dir_rows[i]) begin
      it.func = dir_rows[i].cmd;
      it.tx_byte = dir_rows[i].tx;
      it.line_level = dir_rows[i].line;
      send_beat(it, dir_rows[i].typed, dir_rows[i].res);
      if (dir_rows[i].settle) tick_until_idle(1'b0, dir_rows[i].line);
    end

    quiesce();
    set_timings(1, 1);
    run_random(150);

    quiesce();
    set_mode(65, 24);
    set_timings(0, 0);
    run_random(150);

    quiesce();
    set_mode(0, 0);
    set_timings(0, 6);
    run_random(150);

    quiesce();
    set_mode(24, 65);
    set_timings(1, 4);
    run_random(100);

    quiesce();
    set_mode(65, 24);
    set_timings(0, 10);
    run_random(100);

    quiesce();
    set_mode(0, 0);
    set_timings(1, 3);
    run_random(100);

    quiesce();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
